FILE: hdl/pes_pkg.sv
// package: types, constants and helpers for the pid error statistics block
`timescale 1ns / 1ps
`default_nettype none
package pes_pkg;
    localparam int WIN_DEPTH  = 16;
    localparam int WIN_AW     = 4;
    localparam int DIFF_DEPTH = 4;
    localparam int DIFF_AW    = 2;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_IMIN   = 2'd1;
    localparam logic [1:0] REG_IMAX   = 2'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample;
    } pes_in_t;

    typedef struct packed {
        logic signed [15:0] mean;
        logic [15:0]        rms;
        logic [15:0]        min_rms;
        logic [15:0]        max_rms;
        logic [15:0]        center_rms;
        logic signed [31:0] integral_value;
        logic signed [31:0] derivative;
    } pes_out_t;

    // request between the sequencer and the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [39:0] den;
    } pes_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } pes_div_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/pes_div.sv
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pes_div
    import pes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pes_div_req_t req,
    output pes_div_rsp_t      rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[39:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = trial - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

FILE: hdl/pes_sqrt.sv
// integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pes_sqrt
    import pes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [39:0] radicand,
    output logic             done,
    output logic [19:0]      root
);
    logic [39:0] v_reg, v_next;
    logic [39:0] r_reg, r_next;
    logic [39:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [39:0] rb;

    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rb        = r_reg + bit_reg;
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            bit_next  = 40'h4000000000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= rb)
            begin
                v_next = v_reg - rb;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[19:0];
endmodule
`default_nettype wire

FILE: hdl/pid_error_statistics_core.sv
// top level: window memories, sequencer and result register
// throughput: one request at a time; the shared divider (up to four uses per push)
//   and the square root unit (two uses) bound it
// a clear request skips to the result load; the rms scan covers every filled entry
// reset: async active low on control registers; memories and data need no clearing
`timescale 1ns / 1ps
`default_nettype none
module pid_error_statistics_core
    import pes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pes_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pes_out_t         out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RD     = 5'd1;
    localparam logic [4:0] S_UPD    = 5'd2;
    localparam logic [4:0] S_MDIV   = 5'd3;
    localparam logic [4:0] S_MWAIT  = 5'd4;
    localparam logic [4:0] S_SDIV   = 5'd5;
    localparam logic [4:0] S_SWAIT  = 5'd6;
    localparam logic [4:0] S_SQ     = 5'd7;
    localparam logic [4:0] S_SQWAIT = 5'd8;
    localparam logic [4:0] S_INTEG  = 5'd9;
    localparam logic [4:0] S_CLAMP  = 5'd10;
    localparam logic [4:0] S_SCAN   = 5'd11;
    localparam logic [4:0] S_SCANW  = 5'd12;
    localparam logic [4:0] S_CSQ    = 5'd13;
    localparam logic [4:0] S_CSQW   = 5'd14;
    localparam logic [4:0] S_DDIV   = 5'd15;
    localparam logic [4:0] S_DWAIT  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    // configuration
    logic [23:0]        period_reg;
    logic signed [31:0] imin_reg, imax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 24'd65536;
            imin_reg   <= -32'sd65536;
            imax_reg   <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD: period_reg <= cfg_wdata[23:0];
                REG_IMIN:   imin_reg   <= cfg_wdata;
                REG_IMAX:   imax_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // window memories: sample and square share one address
    logic [47:0] win_mem [WIN_DEPTH];
    logic [15:0] rms_mem [WIN_DEPTH];
    logic [16:0] diff_mem [DIFF_DEPTH];
    logic [47:0] win_rd;
    logic [15:0] rms_rd;
    logic [16:0] diff_rd;
    logic        win_we, rms_we, diff_we;
    logic [WIN_AW-1:0] rms_raddr;

    // control state
    logic [4:0]          state_reg, state_next;
    logic signed [23:0]  ssum_reg, ssum_next;
    logic [39:0]         qsum_reg, qsum_next;
    logic [4:0]          wcnt_reg, wcnt_next;
    logic [WIN_AW-1:0]   wptr_reg, wptr_next;
    logic [4:0]          rcnt_reg, rcnt_next;
    logic [WIN_AW-1:0]   rptr_reg, rptr_next;
    logic signed [19:0]  dsum_reg, dsum_next;
    logic [2:0]          dcnt_reg, dcnt_next;
    logic [DIFF_AW-1:0]  dptr_reg, dptr_next;
    logic signed [31:0]  integ_reg, integ_next;
    logic                out_valid_reg, out_valid_next;

    // per-request working registers
    logic signed [15:0]  smp_reg, smp_next;
    logic signed [15:0]  prev_reg, prev_next;
    logic signed [15:0]  mean_reg, mean_next;
    logic [15:0]         rms_reg, rms_next;
    logic [15:0]         mn_reg, mn_next;
    logic [15:0]         mx_reg, mx_next;
    logic [15:0]         ctr_reg, ctr_next;
    logic signed [31:0]  deriv_reg, deriv_next;
    logic signed [47:0]  prod_reg, prod_next;
    logic [4:0]          scan_reg, scan_next;
    logic                mprev_reg, mprev_next;
    logic                dneg_reg, dneg_next;
    pes_out_t            res_reg, res_next;

    pes_div_req_t div_req;
    pes_div_rsp_t div_rsp;
    logic         sq_start, sq_done;
    logic [39:0]  sq_in;
    logic [19:0]  sq_root;

    pes_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
    pes_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
                     .done(sq_done), .root(sq_root));

    always_ff @(posedge clk)
    begin
        if (win_we)
            win_mem[wptr_reg] <= {smp_reg, 32'(smp_reg * smp_reg)};
        win_rd <= win_mem[wptr_reg];
        if (rms_we)
            rms_mem[rptr_reg] <= rms_reg;
        rms_rd <= rms_mem[rms_raddr];
        if (diff_we)
            diff_mem[dptr_reg] <= 17'(mean_reg - prev_reg);
        diff_rd <= diff_mem[dptr_reg];
    end

    assign rms_raddr = scan_reg[WIN_AW-1:0];

    // helpers
    logic [23:0] abs_sum;
    logic [39:0] clamp_wide;
    logic signed [47:0] integ_sum;
    logic signed [16:0] diff_val;
    logic [31:0] sq_win;
    logic [19:0] abs_d;

    always_comb
    begin
        state_next     = state_reg;
        ssum_next      = ssum_reg;
        qsum_next      = qsum_reg;
        wcnt_next      = wcnt_reg;
        wptr_next      = wptr_reg;
        rcnt_next      = rcnt_reg;
        rptr_next      = rptr_reg;
        dsum_next      = dsum_reg;
        dcnt_next      = dcnt_reg;
        dptr_next      = dptr_reg;
        integ_next     = integ_reg;
        out_valid_next = out_valid_reg;
        smp_next       = smp_reg;
        prev_next      = prev_reg;
        mean_next      = mean_reg;
        rms_next       = rms_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        ctr_next       = ctr_reg;
        deriv_next     = deriv_reg;
        prod_next      = prod_reg;
        scan_next      = scan_reg;
        mprev_next     = mprev_reg;
        dneg_next      = dneg_reg;
        res_next       = res_reg;
        win_we         = 1'b0;
        rms_we         = 1'b0;
        diff_we        = 1'b0;
        div_req        = '0;
        sq_start       = 1'b0;
        sq_in          = '0;
        abs_sum        = ssum_reg[23] ? 24'(-ssum_reg) : 24'(ssum_reg);
        clamp_wide     = '0;
        integ_sum      = 48'(integ_reg) + (prod_reg >>> 8);
        diff_val       = 17'(mean_reg - prev_reg);
        sq_win         = win_rd[31:0];
        abs_d          = dsum_reg[19] ? 20'(-dsum_reg) : 20'(dsum_reg);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next = in_data.sample;
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        ssum_next  = '0;
                        qsum_next  = '0;
                        wcnt_next  = '0;
                        wptr_next  = '0;
                        rcnt_next  = '0;
                        rptr_next  = '0;
                        dsum_next  = '0;
                        dcnt_next  = '0;
                        dptr_next  = '0;
                        integ_next = '0;
                        mean_next  = '0;
                        rms_next   = '0;
                        mn_next    = '0;
                        mx_next    = '0;
                        ctr_next   = '0;
                        deriv_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mprev_next = 1'b1;
                        state_next = S_MDIV;
                    end
                end
            end
            // read the slot to be overwritten and the oldest difference
            S_RD:
                state_next = S_UPD;
            S_UPD:
            begin
                win_we = 1'b1;
                if (wcnt_reg >= 5'(WIN_DEPTH))
                begin
                    ssum_next = ssum_reg - 24'(signed'(win_rd[47:32])) + 24'(smp_reg);
                    qsum_next = qsum_reg - 40'(sq_win) + 40'(32'(smp_reg * smp_reg));
                end
                else
                begin
                    ssum_next = ssum_reg + 24'(smp_reg);
                    qsum_next = qsum_reg + 40'(32'(smp_reg * smp_reg));
                    wcnt_next = wcnt_reg + 5'd1;
                end
                wptr_next  = wptr_reg + 1'b1;
                mprev_next = 1'b0;
                state_next = S_MDIV;
            end
            // rounded mean: (|sum| + n/2) / n
            S_MDIV:
            begin
                if (wcnt_reg == 5'd0)
                begin
                    prev_next  = '0;
                    state_next = S_RD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = 64'(abs_sum) + 64'(wcnt_reg >> 1);
                    div_req.den   = 40'(wcnt_reg);
                    state_next    = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (mprev_reg)
                    begin
                        prev_next  = ssum_reg[23] ? 16'(-div_rsp.quo[15:0])
                                                  : div_rsp.quo[15:0];
                        state_next = S_RD;
                    end
                    else
                    begin
                        mean_next  = ssum_reg[23] ? 16'(-div_rsp.quo[15:0])
                                                  : div_rsp.quo[15:0];
                        state_next = S_SDIV;
                    end
                end
            end
            S_SDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'(qsum_reg);
                div_req.den   = 40'(wcnt_reg);
                state_next    = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    sq_start   = 1'b1;
                    sq_in      = div_rsp.quo[39:0];
                    state_next = S_SQWAIT;
                end
            end
            S_SQ:
                state_next = S_SQWAIT;
            S_SQWAIT:
            begin
                if (sq_done)
                begin
                    rms_next   = sq_root[15:0];
                    prod_next  = 48'(mean_reg) * 48'(signed'({1'b0, period_reg}));
                    state_next = S_INTEG;
                end
            end
            // commit rms history, clamped integral add, difference history
            S_INTEG:
            begin
                rms_we    = 1'b1;
                rptr_next = rptr_reg + 1'b1;
                if (rcnt_reg < 5'(WIN_DEPTH))
                    rcnt_next = rcnt_reg + 5'd1;
                if (integ_sum < 48'(imin_reg))
                    integ_next = imin_reg;
                else
                    integ_next = integ_sum[31:0];
                if (integ_sum < 48'(imin_reg) && imin_reg > imax_reg)
                    integ_next = imax_reg;
                else if (!(integ_sum < 48'(imin_reg)) && integ_sum > 48'(imax_reg))
                    integ_next = imax_reg;
                diff_we = 1'b1;
                if (dcnt_reg >= 3'(DIFF_DEPTH))
                    dsum_next = dsum_reg - 20'(signed'(diff_rd)) + 20'(diff_val);
                else
                begin
                    dsum_next = dsum_reg + 20'(diff_val);
                    dcnt_next = dcnt_reg + 3'd1;
                end
                dptr_next  = dptr_reg + 1'b1;
                scan_next  = '0;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                scan_next  = 5'd1;
                state_next = S_SCANW;
            end
            // history scan: one entry a cycle, registered memory read
            S_SCANW:
            begin
                if (scan_reg == 5'd1)
                begin
                    mn_next = rms_rd;
                    mx_next = rms_rd;
                end
                else
                begin
                    if (rms_rd < mn_reg) mn_next = rms_rd;
                    if (rms_rd > mx_reg) mx_next = rms_rd;
                end
                if (scan_reg >= rcnt_reg)
                    state_next = S_CSQ;
                else
                    scan_next = scan_reg + 5'd1;
            end
            S_SCAN:
                state_next = S_CSQ;
            S_CSQ:
            begin
                sq_start   = 1'b1;
                clamp_wide = 40'(32'(mn_reg) * 32'(mn_reg)) + 40'(32'(mx_reg) * 32'(mx_reg));
                sq_in      = clamp_wide >> 1;
                state_next = S_CSQW;
            end
            S_CSQW:
            begin
                if (sq_done)
                begin
                    ctr_next   = sq_root[15:0];
                    state_next = S_DDIV;
                end
            end
            S_DDIV:
            begin
                dneg_next = dsum_reg[19];
                if (period_reg == 24'd0)
                begin
                    deriv_next = dsum_reg == 20'sd0 ? 32'sd0
                               : (dsum_reg[19] ? 32'h80000000 : 32'h7FFFFFFF);
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {20'd0, abs_d, 24'd0};
                    div_req.den   = 40'(27'(period_reg) * 27'(dcnt_reg));
                    state_next    = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quo[63:31] != 33'd0)
                        deriv_next = dneg_reg ? 32'h80000000 : 32'h7FFFFFFF;
                    else
                        deriv_next = dneg_reg ? 32'(-div_rsp.quo[31:0])
                                              : div_rsp.quo[31:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_OUT;
            // hold until the previous result has been taken, then load the result
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.mean           = mean_reg;
                    res_next.rms            = rms_reg;
                    res_next.min_rms        = mn_reg;
                    res_next.max_rms        = mx_reg;
                    res_next.center_rms     = ctr_reg;
                    res_next.integral_value = integ_reg;
                    res_next.derivative     = deriv_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ssum_reg      <= '0;
            qsum_reg      <= '0;
            wcnt_reg      <= '0;
            wptr_reg      <= '0;
            rcnt_reg      <= '0;
            rptr_reg      <= '0;
            dsum_reg      <= '0;
            dcnt_reg      <= '0;
            dptr_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
            mprev_reg     <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ssum_reg      <= ssum_next;
            qsum_reg      <= qsum_next;
            wcnt_reg      <= wcnt_next;
            wptr_reg      <= wptr_next;
            rcnt_reg      <= rcnt_next;
            rptr_reg      <= rptr_next;
            dsum_reg      <= dsum_next;
            dcnt_reg      <= dcnt_next;
            dptr_reg      <= dptr_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
            mprev_reg     <= mprev_next;
            scan_reg      <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        prev_reg  <= prev_next;
        mean_reg  <= mean_next;
        rms_reg   <= rms_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        ctr_reg   <= ctr_next;
        deriv_reg <= deriv_next;
        prod_reg  <= prod_next;
        dneg_reg  <= dneg_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // window and difference fills never exceed their depths
    a_wcnt: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= 5'(WIN_DEPTH))
        else $error("window count overflow");
    a_dcnt: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= 3'(DIFF_DEPTH))
        else $error("difference count overflow");
    // an accepted request always moves the sequencer out of idle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != S_IDLE)
        else $error("request accepted without starting");
    // a pending result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("result dropped");
endmodule
`default_nettype wire
